[rtl/core/prat_pkg.sv]
// Shared constants and types for the pairwise running average table.
package prat_pkg;

	localparam int NODES_DEF = 256;
	localparam int MAX_DESTS_DEF = 4;
	localparam int VALUE_BITS_DEF = 10;

	localparam int HIT_W = 16;
	localparam int NODE_PORT_W = 8;
	localparam int VAL_PORT_W = 10;

	typedef enum logic {
		CMD_LOOKUP = 1'b0,
		CMD_UPDATE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_LOOKUP   = 2'd0,
		STATUS_INSERTED = 2'd1,
		STATUS_AVERAGED = 2'd2,
		STATUS_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_NODE,
		ST_SCAN,
		ST_EXEC,
		ST_DIV,
		ST_ROUND,
		ST_DONE
	} state_t;

endpackage

[rtl/core/pairwise_running_average_table.sv]
// Pairwise running average table: per-source destination slots with a per-source hit counter shared by its slots.
//
// The block handles one request at a time. After reset it clears the per-source memory
// entry by entry and holds in_stall high meanwhile. A lookup, an insert or a table-full
// request reads the node entry of its source and then scans the used slots of that source
// (at most MAX_DESTS, one slot memory read per cycle) until one matches. An update that
// changes a stored value also runs a restoring divider that retires one quotient bit per
// cycle over the 16 + VALUE_BITS + 1 bit sum. The result register lets a new request
// enter while the previous result still waits on out_stall.
module pairwise_running_average_table
	import prat_pkg::*;
#(
	parameter int NODES = NODES_DEF,
	parameter int MAX_DESTS = MAX_DESTS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   command,
	input  logic [NODE_PORT_W-1:0] source_node,
	input  logic [NODE_PORT_W-1:0] dest_node,
	input  logic [VAL_PORT_W-1:0]  new_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [VAL_PORT_W-1:0]  value,
	output logic                   found,
	output logic [1:0]             status
);

	localparam int NODE_W = $clog2(NODES);
	localparam int SLOTS = NODES * MAX_DESTS;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int IDX_W = $clog2(MAX_DESTS + 1);
	localparam int SUM_W = HIT_W + VALUE_BITS + 1;
	localparam int DIV_W = HIT_W + 1;
	localparam int STEP_W = $clog2(SUM_W);
	localparam int WIDE_W = (VALUE_BITS > VAL_PORT_W) ? VALUE_BITS : VAL_PORT_W;
	localparam int RED_W = NODE_PORT_W + 13;
	localparam logic [RED_W-1:0] NODES_R = RED_W'(NODES);
	localparam logic [VALUE_BITS-1:0] VMASK = {VALUE_BITS{1'b1}};
	localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

	typedef struct packed {
		logic [IDX_W-1:0] count;
		logic [HIT_W-1:0] hits;
	} node_ent_t;

	typedef struct packed {
		logic [NODE_PORT_W-1:0] dest;
		logic [VALUE_BITS-1:0]  val;
	} slot_ent_t;

	function automatic logic [NODE_W-1:0] reduce_src(input logic [NODE_PORT_W-1:0] s);
		logic [RED_W-1:0] r;
		r = RED_W'(s);
		for (int k = NODE_PORT_W - 1; k >= 0; k--) begin
			if (r >= (NODES_R << k)) begin
				r = r - (NODES_R << k);
			end
		end
		return r[NODE_W-1:0];
	endfunction

	state_t state_q, state_d;

	logic                   cmd_q;
	logic [NODE_W-1:0]      src_q;
	logic [NODE_PORT_W-1:0] dst_q;
	logic [VALUE_BITS-1:0]  nv_q;
	logic [IDX_W-1:0]       count_q;
	logic [HIT_W-1:0]       hits_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       slot_idx_q;
	logic                   hit_q;
	logic [VALUE_BITS-1:0]  old_q;
	logic [NODE_W-1:0]      clr_q;

	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  quo_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  div_q;
	logic [STEP_W-1:0] step_q;

	logic [VALUE_BITS-1:0] res_value_q;
	logic                  res_found_q;
	status_t               res_status_q;

	logic                  out_valid_q;
	logic [VAL_PORT_W-1:0] value_q;
	logic                  found_q;
	logic [1:0]            status_q;

	logic            node_we, node_re;
	logic [NODE_W-1:0] node_waddr, node_raddr;
	node_ent_t       node_wdata, node_rdata;

	logic            slot_we, slot_re;
	logic [SLOT_W-1:0] slot_waddr, slot_raddr;
	slot_ent_t       slot_wdata, slot_rdata;

	logic                  in_take;
	logic                  out_load;
	logic [NODE_W-1:0]     src_in;
	logic [VALUE_BITS-1:0] nv_in;
	logic [IDX_W-1:0]      count_rd;
	logic [SLOT_W-1:0]     base;
	logic                  slot_match;
	logic                  more_slots;
	logic [DIV_W:0]        rem_sh;
	logic [SUM_W:0]        q_round;
	logic [VALUE_BITS-1:0] avg_val;
	logic [HIT_W-1:0]      hits_inc;
	logic [WIDE_W-1:0]     nv_wide;
	logic [WIDE_W-1:0]     res_wide;

	assign in_take = in_valid && !in_stall;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign src_in = reduce_src(source_node);
	assign nv_wide = WIDE_W'(new_value);
	assign nv_in = nv_wide[VALUE_BITS-1:0];
	assign count_rd = (node_rdata.count > IDX_W'(MAX_DESTS)) ? IDX_W'(MAX_DESTS)
		: node_rdata.count;
	assign base = SLOT_W'(src_q * MAX_DESTS);
	assign slot_match = (slot_rdata.dest == dst_q);
	assign more_slots = ((idx_q + IDX_W'(1)) < count_q);
	assign rem_sh = {rem_q, sum_q[SUM_W-1]};
	assign q_round = {1'b0, quo_q} + (SUM_W + 1)'(rem_q >= (div_q >> 1));
	assign avg_val = (q_round > (SUM_W + 1)'(VMASK)) ? VMASK : q_round[VALUE_BITS-1:0];
	assign hits_inc = (hits_q < HIT_MAX) ? hits_q + HIT_W'(1) : hits_q;
	assign res_wide = WIDE_W'(res_value_q);

	prat_ram #(
		.WIDTH($bits(node_ent_t)),
		.DEPTH(NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.re    (node_re),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	prat_ram #(
		.WIDTH($bits(slot_ent_t)),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == NODE_W'(NODES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_take) begin
					state_d = ST_NODE;
				end
			end
			ST_NODE: begin
				state_d = (count_rd == '0) ? ST_EXEC : ST_SCAN;
			end
			ST_SCAN: begin
				if (slot_match || !more_slots) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (cmd_q == CMD_UPDATE && hit_q && nv_q != old_q) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (step_q == STEP_W'(SUM_W - 1)) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		node_we = 1'b0;
		node_waddr = src_q;
		node_wdata = '{count: count_q, hits: hits_q};
		node_re = 1'b0;
		node_raddr = src_in;
		slot_we = 1'b0;
		slot_waddr = base + SLOT_W'(count_q);
		slot_wdata = '{dest: dst_q, val: nv_q};
		slot_re = 1'b0;
		slot_raddr = base;
		case (state_q)
			ST_CLEAR: begin
				node_we = 1'b1;
				node_waddr = clr_q;
				node_wdata = '{count: '0, hits: HIT_W'(1)};
			end
			ST_IDLE: begin
				node_re = in_take;
			end
			ST_NODE: begin
				slot_re = (count_rd != '0);
			end
			ST_SCAN: begin
				slot_re = !slot_match && more_slots;
				slot_raddr = base + SLOT_W'(idx_q + IDX_W'(1));
			end
			ST_EXEC: begin
				if (cmd_q == CMD_UPDATE) begin
					if (hit_q) begin
						node_we = 1'b1;
						node_wdata = '{count: count_q, hits: hits_inc};
					end else if (count_q < IDX_W'(MAX_DESTS)) begin
						node_we = 1'b1;
						node_wdata = '{count: count_q + IDX_W'(1), hits: hits_q};
						slot_we = 1'b1;
					end
				end
			end
			ST_ROUND: begin
				slot_we = 1'b1;
				slot_waddr = base + SLOT_W'(slot_idx_q);
				slot_wdata = '{dest: dst_q, val: avg_val};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + NODE_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					cmd_q <= command;
					src_q <= src_in;
					dst_q <= dest_node;
					nv_q <= nv_in;
					hit_q <= 1'b0;
				end
			end
			ST_NODE: begin
				count_q <= count_rd;
				hits_q <= node_rdata.hits;
				idx_q <= '0;
			end
			ST_SCAN: begin
				if (slot_match) begin
					hit_q <= 1'b1;
					old_q <= slot_rdata.val;
					slot_idx_q <= idx_q;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			ST_EXEC: begin
				sum_q <= SUM_W'(nv_q) + SUM_W'(hits_q) * SUM_W'(old_q);
				div_q <= DIV_W'(hits_q) + DIV_W'(1);
				rem_q <= '0;
				quo_q <= '0;
				step_q <= '0;
				res_found_q <= hit_q;
				if (cmd_q == CMD_LOOKUP) begin
					res_value_q <= hit_q ? old_q : '0;
					res_status_q <= STATUS_LOOKUP;
				end else if (hit_q) begin
					res_value_q <= old_q;
					res_status_q <= STATUS_AVERAGED;
				end else if (count_q < IDX_W'(MAX_DESTS)) begin
					res_value_q <= nv_q;
					res_status_q <= STATUS_INSERTED;
				end else begin
					res_value_q <= '0;
					res_status_q <= STATUS_FULL;
				end
			end
			ST_DIV: begin
				sum_q <= sum_q << 1;
				step_q <= step_q + STEP_W'(1);
				if (rem_sh >= {1'b0, div_q}) begin
					rem_q <= DIV_W'(rem_sh - {1'b0, div_q});
					quo_q <= {quo_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[DIV_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], 1'b0};
				end
			end
			ST_ROUND: begin
				res_value_q <= avg_val;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			value_q <= res_wide[VAL_PORT_W-1:0];
			found_q <= res_found_q;
			status_q <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value = value_q;
	assign found = found_q;
	assign status = status_q;

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("A second request was taken while one was in flight.");

	a_node_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		node_we |-> (state_q == ST_CLEAR || state_q == ST_EXEC))
		else $error("Node memory written outside the clear pass or execute step.");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("Result presented without a finished request.");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> idx_q < count_q)
		else $error("Slot scan ran past the used slots.");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_ROUND) |-> rem_q < div_q)
		else $error("Divider remainder not below divisor.");

endmodule

[rtl/core/prat_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
module prat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
